### rtl/core/mep_pkg.sv
// Shared types, constants and codes for the Mandelbrot escape-time pixel block.
// No dependencies; imported by every module under rtl/core.
package mep_pkg;

   // Fixed-point and image geometry
   localparam int IMAGE_WIDTH = 1024;
   localparam int FRAC_BITS   = 28;
   localparam int COORD_W     = 10;
   localparam int COUNT_W     = 16;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 64;

   // Register file
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_RE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_IM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_GAIN = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [COUNT_W-1:0] escape_count;
      logic [31:0]        pixel_value;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_iterations;
      logic [30:0]        pixel_step;
      logic signed [31:0] offset_real;
      logic signed [31:0] offset_imag;
      logic [31:0]        color_gain;
   } cfg_type;

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      OP_MAP_RE,
      OP_MAP_IM,
      OP_RR,
      OP_II,
      OP_RI,
      OP_COLOR
   } mul_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAP_RE,
      S_MAP_IM,
      S_MAP_DONE,
      S_START,
      S_UPDATE,
      S_SQ_R,
      S_SQ_I,
      S_ESCAPE,
      S_COLOR_MUL,
      S_COLOR_OUT
   } state_type;

   // Sequencer to datapath
   typedef struct packed {
      mul_op_type op;
      logic       take_req;
      logic       load_cr;
      logic       load_ci;
      logic       load_z;
      logic       load_sq_r;
      logic       load_sq_i;
      logic       inc_iter;
      logic       count_zero;
      logic       count_iter;
      logic       load_rsp;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic max_zero;
      logic iter_last;
      logic escaped;
      logic rsp_free;
   } stat_type;

endpackage

### rtl/core/mep_csr.sv
// Configuration register file of the escape-time block.
// Depends on mep_pkg for the register codes and cfg_type.
module mep_csr
   import mep_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   // Writes are always accepted
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_ITER:   cfg_in.max_iterations = csr_data[COUNT_W-1:0];
            CSR_PIXEL_STEP: cfg_in.pixel_step     = csr_data[30:0];
            CSR_OFFSET_RE:  cfg_in.offset_real    = $signed(csr_data);
            CSR_OFFSET_IM:  cfg_in.offset_imag    = $signed(csr_data);
            CSR_COLOR_GAIN: cfg_in.color_gain     = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= 16'd50;
         cfg_ff.pixel_step     <= 31'd1048576;
         cfg_ff.offset_real    <= '0;
         cfg_ff.offset_imag    <= '0;
         cfg_ff.color_gain     <= 32'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/mep_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mep_pkg for operand and product widths.
module mep_mul
   import mep_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [2*MUL_W-1:0] full;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   // Every use fits in 64 bits; the color product only keeps its low word
   assign full    = op_a * op_b;
   assign prod_in = full[PROD_W-1:0];
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/core/mep_seq.sv
// Sequencer: steps mapping, the z = z^2 + c loop and the color product
// through the shared multiplier. Depends on mep_pkg (state_type, ctrl/stat).
module mep_seq
   import mep_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_MAP_RE;
         S_MAP_RE:    state_in = S_MAP_IM;
         S_MAP_IM:    state_in = S_MAP_DONE;
         S_MAP_DONE:  state_in = S_START;
         S_START:     state_in = stat.max_zero ? S_COLOR_MUL : S_UPDATE;
         S_UPDATE:    state_in = S_SQ_R;
         S_SQ_R:      state_in = S_SQ_I;
         S_SQ_I:      state_in = S_ESCAPE;
         S_ESCAPE: begin
            if (stat.escaped || stat.iter_last) state_in = S_COLOR_MUL;
            else                                state_in = S_UPDATE;
         end
         S_COLOR_MUL: state_in = S_COLOR_OUT;
         S_COLOR_OUT: if (stat.rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl      = '0;
      ctrl.op   = OP_RI;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            ctrl.take_req = req_valid;
         end
         S_MAP_RE: ctrl.op = OP_MAP_RE;
         S_MAP_IM: begin
            ctrl.op      = OP_MAP_IM;
            ctrl.load_cr = 1'b1;
         end
         S_MAP_DONE: ctrl.load_ci = 1'b1;
         S_START: begin
            ctrl.op         = OP_RI;
            ctrl.count_zero = stat.max_zero;
         end
         S_UPDATE: ctrl.load_z = 1'b1;
         S_SQ_R:   ctrl.op     = OP_RR;
         S_SQ_I: begin
            ctrl.op        = OP_II;
            ctrl.load_sq_r = 1'b1;
         end
         S_ESCAPE: begin
            // cross product of the new z is issued whether or not the loop ends
            ctrl.op         = OP_RI;
            ctrl.load_sq_i  = 1'b1;
            ctrl.count_iter = stat.escaped;
            ctrl.count_zero = !stat.escaped && stat.iter_last;
            ctrl.inc_iter   = !stat.escaped && !stat.iter_last;
         end
         S_COLOR_MUL: ctrl.op = OP_COLOR;
         S_COLOR_OUT: begin
            // keep the color product in the multiplier while the output is busy
            ctrl.op       = OP_COLOR;
            ctrl.load_rsp = stat.rsp_free;
         end
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/mep_dpath.sv
// Datapath: plane point, z and square registers, iteration counter,
// multiplier operand select and the result register.
// Depends on mep_pkg and instantiates mep_mul.
module mep_dpath
   import mep_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload,
   input  cfg_type  cfg,
   input  ctrl_type ctrl,
   output stat_type stat
);

   localparam logic             HAS_LIMIT = (2 * FRAC_BITS + 2) < 64;
   localparam logic [63:0]      ESC_LIMIT = HAS_LIMIT ? (64'd4 << (2 * FRAC_BITS)) : 64'd0;
   localparam logic signed [MUL_W-1:0] HALF_W = MUL_W'(IMAGE_WIDTH / 2);

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)       sat32 = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
      else                           sat32 = v[31:0];
   endfunction

   logic [COORD_W-1:0]      x_ff, y_ff;
   logic signed [31:0]      cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [PROD_W-1:0] sq_r_ff, sq_i_ff;
   logic [COUNT_W-1:0]      iter_ff, count_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] diff, re_sum, im_sum, map_re, map_im;
   logic [63:0]              mag;
   logic [19:0]              count12;

   // Count times twelve as two shifted copies
   assign count12 = (20'(count_ff) << 3) + (20'(count_ff) << 2);

   // Operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.op)
         OP_MAP_RE: begin
            op_a = $signed({{(MUL_W-COORD_W){1'b0}}, x_ff}) - HALF_W;
            op_b = $signed({2'b00, cfg.pixel_step});
         end
         OP_MAP_IM: begin
            op_a = $signed({{(MUL_W-COORD_W){1'b0}}, y_ff}) - HALF_W;
            op_b = $signed({2'b00, cfg.pixel_step});
         end
         OP_RR: begin
            op_a = MUL_W'(zr_ff);
            op_b = MUL_W'(zr_ff);
         end
         OP_II: begin
            op_a = MUL_W'(zi_ff);
            op_b = MUL_W'(zi_ff);
         end
         OP_RI: begin
            op_a = MUL_W'(zr_ff);
            op_b = MUL_W'(zi_ff);
         end
         OP_COLOR: begin
            op_a = $signed({1'b0, cfg.color_gain});
            op_b = $signed({13'd0, count12});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   mep_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Point mapping: exact product plus offset, then saturate
   assign map_re = prod + PROD_W'(cfg.offset_real);
   assign map_im = prod + PROD_W'(cfg.offset_imag);

   // z update: prod holds zr*zi here
   assign diff   = sq_r_ff - sq_i_ff;
   assign re_sum = (diff >>> FRAC_BITS) + PROD_W'(cr_ff);
   assign im_sum = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_ff);

   // Escape test: prod holds zi^2 of the new z here
   assign mag = 64'(sq_r_ff) + 64'(prod);

   assign stat.max_zero  = (cfg.max_iterations == '0);
   assign stat.iter_last = ((iter_ff + 16'd1) == cfg.max_iterations);
   assign stat.escaped   = HAS_LIMIT && (mag > ESC_LIMIT);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Working registers
   always_ff @(posedge clock) begin
      if (ctrl.take_req) begin
         x_ff <= req_payload.pixel_x;
         y_ff <= req_payload.pixel_y;
      end
      if (ctrl.load_cr) cr_ff <= sat32(map_re);
      if (ctrl.load_ci) begin
         ci_ff   <= sat32(map_im);
         zr_ff   <= '0;
         zi_ff   <= '0;
         sq_r_ff <= '0;
         sq_i_ff <= '0;
         iter_ff <= '0;
      end
      if (ctrl.load_z) begin
         zr_ff <= sat32(re_sum);
         zi_ff <= sat32(im_sum);
      end
      if (ctrl.load_sq_r) sq_r_ff <= prod;
      if (ctrl.load_sq_i) sq_i_ff <= prod;
      if (ctrl.inc_iter)   iter_ff  <= iter_ff + 16'd1;
      if (ctrl.count_zero) count_ff <= '0;
      if (ctrl.count_iter) count_ff <= iter_ff;
      if (ctrl.load_rsp) begin
         rsp_ff.out_x        <= x_ff;
         rsp_ff.out_y        <= y_ff;
         rsp_ff.escape_count <= count_ff;
         rsp_ff.pixel_value  <= prod[31:0];
      end
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel evaluator, top level.
// Per pixel: mapping, k iterations of z = z^2 + c (k = escape count + 1, or the limit;
// 0 for a zero limit) and the color product; each iteration runs update, zr^2, zi^2
// and escape test on the one shared 33x33 multiplier. A new pixel is taken only after
// the last result is loaded; a finished result may wait in the output register while
// the next pixel is taken. Sync reset restores defaults.
module mandelbrot_escape_pixel
   import mep_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type  cfg;
   ctrl_type ctrl;
   stat_type stat;

   mep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mep_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mep_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cfg         (cfg),
      .ctrl        (ctrl),
      .stat        (stat)
   );

endmodule

### bench/escape_checker.sv
// Checker for the Mandelbrot escape-time pixel block: mirrors the CSRs, predicts each
// pixel's escape count and color, and compares every result transaction in order.
// Depends on mep_pkg for the payload types, register indexes and fixed-point constants.
module escape_checker
   import mep_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output int unsigned          error_count,
   output int unsigned          open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint          HALF_WIDTH = IMAGE_WIDTH / 2;
   localparam longint          INT32_HI   = 64'sd2147483647;
   localparam longint          INT32_LO   = -64'sd2147483648;
   // 4.0 squared-radius threshold; only meaningful while it fits in 64 bits
   localparam bit              HAS_RADIUS = (2 * FRAC_BITS + 2) < 64;
   localparam longint unsigned RADIUS_SQ  = 64'd4 << (2 * FRAC_BITS);

   // CSR mirror
   int unsigned     iter_max;
   longint          pixel_step_q;
   longint          offset_re;
   longint          offset_im;
   longint unsigned color_gain_q;

   // predicted results, oldest first
   rsp_type         expected_pixels [$];

   function automatic longint clamp32(input longint v);
      if (v > INT32_HI) return INT32_HI;
      if (v < INT32_LO) return INT32_LO;
      return v;
   endfunction

   // Map the pixel onto the plane, run z = z^2 + c, then derive the color
   function automatic rsp_type predict_escape(input req_type px);
      longint          col, row, cr, ci, zr, zi, nr, ni;
      longint unsigned mag;
      int unsigned     n;
      bit              gone;
      rsp_type         r;
      col = px.pixel_x;
      row = px.pixel_y;
      cr  = clamp32((col - HALF_WIDTH) * pixel_step_q + offset_re);
      ci  = clamp32((row - HALF_WIDTH) * pixel_step_q + offset_im);
      zr   = 0;
      zi   = 0;
      n    = 0;
      gone = 1'b0;
      while (!gone && n < iter_max) begin
         // squares floor toward minus infinity; cross term carries the factor two
         nr = clamp32(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
         ni = clamp32(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
         zr = nr;
         zi = ni;
         mag = unsigned'(zr * zr) + unsigned'(zi * zi);
         if (HAS_RADIUS && mag > RADIUS_SQ)
            gone = 1'b1;
         else
            n++;
      end
      // reaching the limit counts as inside the set
      if (!gone)
         n = 0;
      r.out_x        = px.pixel_x;
      r.out_y        = px.pixel_y;
      r.escape_count = COUNT_W'(n);
      r.pixel_value  = 32'(color_gain_q * (n * 12));
      return r;
   endfunction

   task automatic mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         iter_max     = 50;
         pixel_step_q = 1 << 20;
         offset_re    = 0;
         offset_im    = 0;
         color_gain_q = 1;
         expected_pixels.delete();
         error_count  = 0;
      end else begin
         // result transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result with nothing expected, actual x=%0d y=%0d count=%0d value=0x%0h",
                        $time, rsp_payload.out_x, rsp_payload.out_y,
                        rsp_payload.escape_count, rsp_payload.pixel_value);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.out_x !== want.out_x)
                  mismatch("out_x", want.out_x, rsp_payload.out_x);
               if (rsp_payload.out_y !== want.out_y)
                  mismatch("out_y", want.out_y, rsp_payload.out_y);
               if (rsp_payload.escape_count !== want.escape_count)
                  mismatch("escape_count", want.escape_count, rsp_payload.escape_count);
               if (rsp_payload.pixel_value !== want.pixel_value)
                  mismatch("pixel_value", want.pixel_value, rsp_payload.pixel_value);
            end
         end

         // pixel transaction: predict with the current register values
         if (req_valid && req_ready)
            expected_pixels.push_back(predict_escape(req_payload));

         // register write; unused indexes change nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_ITER:   iter_max     = csr_data[COUNT_W-1:0];
               CSR_PIXEL_STEP: pixel_step_q = csr_data[30:0];
               CSR_OFFSET_RE:  offset_re    = $signed(csr_data);
               CSR_OFFSET_IM:  offset_im    = $signed(csr_data);
               CSR_COLOR_GAIN: color_gain_q = csr_data;
               default: ;
            endcase
         end
      end
      open_count = expected_pixels.size();
   end

endmodule

### bench/testbench.sv
// Top of the escape-time pixel bench: clock, reset, pixel and CSR stimulus, result
// back-pressure, timeout and verdict. Depends on mep_pkg, mandelbrot_escape_pixel and
// escape_checker.
module testbench
   import mep_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 930;
   localparam int unsigned HOLD_CYCLES  = 2000;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   int unsigned fail_total;
   int unsigned open_total;
   int unsigned iter_limit;
   int unsigned cycles = 0;
   bit          steady = 1'b0;
   bit          hold_off = 1'b0;
   bit          held = 1'b0;

   mandelbrot_escape_pixel dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   escape_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (fail_total),
      .open_count  (open_total)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Q4.28 pan: mostly within +-2.0, sometimes the range ends
   function automatic logic [31:0] pick_offset();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return 32'h8000_0000;
      if (roll < 10) return 32'h7FFF_FFFF;
      return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
   endfunction

   // Result side: random ready, with one long hold once the random part starts
   initial begin
      int unsigned lull;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         lull = idle_cycles();
         if (lull > 0) begin
            rsp_ready <= 1'b0;
            repeat (lull) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // One pixel transaction; valid holds until accepted
   task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int unsigned gap;
      gap = steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{pixel_x: x, pixel_y: y};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop the pixel channel and wait until every result is back
   task automatic settle(input int unsigned extra);
      req_valid <= 1'b0;
      do @(negedge clock); while (open_total != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Write all five registers in index order; optionally poke the unused indexes too
   task automatic write_regs(input logic [31:0] mi, input logic [31:0] st,
                             input logic [31:0] ore, input logic [31:0] oim,
                             input logic [31:0] gn, input bit with_unused);
      logic [31:0] field [5];
      int unsigned last;
      field = '{mi, st, ore, oim, gn};
      last  = with_unused ? (2 ** CSR_IDX_W) - 1 : CSR_COLOR_GAIN;
      for (int unsigned i = CSR_MAX_ITER; i <= last; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= (i <= CSR_COLOR_GAIN) ? field[i] : $urandom;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid  <= 1'b0;
      iter_limit = mi[COUNT_W-1:0];
   endtask

   // Stimulus
   initial begin
      int unsigned sent, shift, roll;
      logic [31:0] mi, st, ore, oim, gn;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      iter_limit  = 50;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values: corners, center (inside the set) and a few framed points
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(512, 512);
      send_pixel(0, 1023);
      send_pixel(1023, 0);
      send_pixel(256, 512);
      send_pixel(640, 600);
      send_pixel(384, 700);

      // zero iteration limit: nothing runs, count and value are zero
      settle(8);
      write_regs(0, 32'd1 << 20, 0, 0, 32'd5, 1'b0);
      send_pixel(512, 512);
      send_pixel(100, 900);

      // limit of one with full gain
      settle(8);
      write_regs(1, 32'd1 << 20, 0, 0, 32'hFFFF_FFFF, 1'b0);
      send_pixel(512, 512);
      send_pixel(0, 0);
      send_pixel(300, 520);

      // zero step: every pixel lands on the pan point (-0.75, 0.1)
      settle(8);
      write_regs(50, 0, 32'hF400_0000, 32'h0199_999A, 32'd7, 1'b0);
      send_pixel(0, 0);
      send_pixel(1023, 1023);

      // top limit, smallest step, c near 1.0: escapes after two or three steps
      settle(8);
      write_regs(65535, 1, 32'h1000_0000, 0, 32'hFFFF_FFFF, 1'b0);
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(512, 512);

      // largest step and extreme pans: c saturates, zero gain, unused indexes ignored
      settle(8);
      write_regs(65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1);
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(512, 512);
      send_pixel(0, 1023);

      // random phases: new registers per phase, random pixels
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle(8);
         hold_off <= 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 10)
            mi = 1;
         else if (roll < 60)
            mi = $urandom_range(2, 32);
         else if (roll < 90)
            mi = $urandom_range(33, 80);
         else
            mi = $urandom_range(81, 128);
         roll = $urandom_range(0, 99);
         if (roll < 4)
            st = 0;
         else if (roll < 8)
            st = 1;
         else if (roll < 12)
            st = 32'h7FFF_FFFF;
         else begin
            shift = $urandom_range(12, 21);
            st    = (32'd1 << shift) | $urandom_range(0, (32'd1 << shift) - 1);
         end
         ore  = pick_offset();
         oim  = pick_offset();
         roll = $urandom_range(0, 99);
         gn   = (roll < 5) ? 32'd0 : (roll < 10) ? 32'hFFFF_FFFF : $urandom;
         write_regs(mi, st, ore, oim, gn, 1'b0);
         // some phases run back to back with no sender gaps
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(30, 120)) begin
            send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)));
            sent++;
         end
      end

      settle(4 * iter_limit + 20);
      @(negedge clock);
      if (fail_total == 0 && open_total == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
